[rtl/core/mlp221_pkg.sv]
// shared types, constants and helpers for the 2-2-1 perceptron core
// used by the hidden lanes, the output merge stage and the top level
package mlp221_pkg;

    localparam int HIDDEN_NEURONS = 2;
    localparam int NET_INPUTS     = 2;
    localparam int HID_WEIGHTS    = (NET_INPUTS + 1) * HIDDEN_NEURONS;
    localparam int OUT_WEIGHTS    = HIDDEN_NEURONS + 1;
    localparam int STEPS          = 61;

    localparam logic [1:0] OP_INFER = 2'd0;
    localparam logic [1:0] OP_TRAIN = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [11:0] LR_RESET = 12'd1024;

    typedef logic [9:0] act_t;

    typedef struct packed {
        logic hmul;
        logic hsum;
        logic hact;
        logic omul;
        logic osum;
        logic oact;
        logic d1;
        logic d2;
        logic d3;
        logic d4;
        logic d5;
        logic d6;
    } ctrl_t;

    typedef struct packed {
        logic              en;
        logic [1:0]        row;
        logic signed [15:0] value;
    } wr_t;

    localparam int EDGES [STEPS] = '{
        -4198, -3686, -3379, -3072, -2867, -2662, -2560, -2355, -2252, -2150,
        -2048, -1945, -1843, -1740, -1638, -1536, -1433, -1331, -1228, -1126,
        -1024, -921, -819, -716, -614, -512, -409, -307, -204, -102,
        0, 103, 205, 308, 410, 512, 615, 717, 922, 1024,
        1127, 1229, 1332, 1434, 1536, 1639, 1741, 1844, 1946, 2048,
        2151, 2253, 2356, 2458, 2663, 2765, 2970, 3175, 3482, 3789,
        4404
    };

    localparam int LEVELS [STEPS + 1] = '{
        10, 20, 31, 41, 51, 61, 72, 82, 92, 102,
        113, 123, 133, 143, 154, 174, 184, 205, 215, 236,
        256, 276, 297, 317, 338, 358, 389, 410, 440, 461,
        492, 512, 532, 563, 584, 614, 635, 666, 717, 727,
        748, 768, 788, 799, 819, 840, 850, 870, 881, 891,
        901, 911, 922, 932, 942, 952, 963, 973, 983, 993,
        1004, 1014
    };

    function automatic act_t activate(input logic signed [15:0] net);
        logic [5:0] k;
        k = '0;
        for (int i = 0; i < STEPS; i++) begin
            if (int'(net) >= EDGES[i]) begin
                k = 6'(i + 1);
            end
        end
        return act_t'(LEVELS[k]);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767) begin
            return 16'sh7fff;
        end else if (v < -48'sd32768) begin
            return -16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage

[rtl/core/mlp221_hlane.sv]
// one hidden neuron lane: forward sum, activation, delta and weight update
// depends on mlp221_pkg
module mlp221_hlane (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mlp221_pkg::ctrl_t      ctrl,
    input  mlp221_pkg::wr_t        wr,
    input  logic signed [15:0]     x0,
    input  logic signed [15:0]     x1,
    input  logic signed [10:0]     dout,
    input  logic signed [15:0]     wout,
    input  logic [11:0]            lr,
    output mlp221_pkg::act_t       h
);
    import mlp221_pkg::*;

    logic signed [15:0] b_reg, w1_reg, w2_reg;
    logic signed [31:0] p0_reg, p1_reg;
    logic signed [15:0] net_reg;
    act_t               h_reg;
    logic [18:0]        q_reg;
    logic signed [26:0] r_reg;
    logic signed [13:0] dh_reg;
    logic signed [26:0] lrh_reg;

    logic signed [33:0] hsum;
    logic [20:0]        qf;
    logic signed [26:0] rprod;
    logic signed [46:0] dprod;
    logic signed [26:0] lrh_next;
    logic signed [42:0] m0, m1;
    logic signed [15:0] b_next, w1_next, w2_next;

    assign hsum = 34'($signed({b_reg, 10'b0})) + 34'(p0_reg) + 34'(p1_reg);
    assign qf = {11'b0, h_reg} * (21'd1024 - {11'b0, h_reg});
    assign rprod = 27'(dout) * 27'(wout);
    assign dprod = 47'(r_reg) * 47'($signed({1'b0, q_reg}));
    assign lrh_next = 27'($signed({1'b0, lr})) * 27'(dh_reg);
    assign m0 = 43'(lrh_reg) * 43'(x0);
    assign m1 = 43'(lrh_reg) * 43'(x1);
    assign b_next  = sat16(48'(b_reg) + 48'(lrh_reg >>> 10));
    assign w1_next = sat16(48'(w1_reg) + 48'(m0 >>> 20));
    assign w2_next = sat16(48'(w2_reg) + 48'(m1 >>> 20));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_reg  <= '0;
            w1_reg <= '0;
            w2_reg <= '0;
        end else if (wr.en) begin
            case (wr.row)
                2'd0:    b_reg  <= wr.value;
                2'd1:    w1_reg <= wr.value;
                2'd2:    w2_reg <= wr.value;
                default: ;
            endcase
        end else if (ctrl.d6) begin
            b_reg  <= b_next;
            w1_reg <= w1_next;
            w2_reg <= w2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.hmul) begin
            p0_reg <= 32'(w1_reg) * 32'(x0);
            p1_reg <= 32'(w2_reg) * 32'(x1);
        end
        if (ctrl.hsum) begin
            net_reg <= sat16(48'(hsum >>> 10));
        end
        if (ctrl.hact) begin
            h_reg <= activate(net_reg);
        end
        if (ctrl.d1) begin
            q_reg <= qf[18:0];
        end
        if (ctrl.d3) begin
            r_reg <= rprod;
        end
        if (ctrl.d4) begin
            dh_reg <= dprod[43:30];
        end
        if (ctrl.d5) begin
            lrh_reg <= lrh_next;
        end
    end

    assign h = h_reg;

endmodule

[rtl/core/mlp221_merge.sv]
// output neuron merging the hidden lanes: sum, activation, output delta
// and output weight update; depends on mlp221_pkg
module mlp221_merge (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mlp221_pkg::ctrl_t      ctrl,
    input  mlp221_pkg::wr_t        wr,
    input  mlp221_pkg::act_t       h0,
    input  mlp221_pkg::act_t       h1,
    input  logic [10:0]            tgt,
    input  logic [11:0]            lr,
    output mlp221_pkg::act_t       s,
    output logic signed [10:0]     dout,
    output logic signed [15:0]     wo1,
    output logic signed [15:0]     wo2
);
    import mlp221_pkg::*;

    logic signed [15:0] bo_reg, wo1_reg, wo2_reg;
    logic signed [26:0] po1_reg, po2_reg;
    logic signed [15:0] net_reg;
    act_t               s_reg;
    logic signed [22:0] e_reg;
    logic signed [10:0] dout_reg;
    logic signed [23:0] lro_reg;

    logic signed [27:0] osum;
    logic signed [11:0] err;
    logic signed [34:0] dprod;
    logic signed [34:0] m1, m2;

    assign osum = 28'($signed({bo_reg, 10'b0})) + 28'(po1_reg) + 28'(po2_reg);
    assign err = $signed({1'b0, tgt}) - $signed({2'b0, s_reg});
    assign dprod = 35'(e_reg) * 35'($signed(12'd1024 - {2'b0, s_reg}));
    assign m1 = 35'(lro_reg) * 35'($signed({1'b0, h0}));
    assign m2 = 35'(lro_reg) * 35'($signed({1'b0, h1}));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bo_reg  <= '0;
            wo1_reg <= '0;
            wo2_reg <= '0;
        end else if (wr.en) begin
            case (wr.row)
                2'd0:    bo_reg  <= wr.value;
                2'd1:    wo1_reg <= wr.value;
                2'd2:    wo2_reg <= wr.value;
                default: ;
            endcase
        end else if (ctrl.d4) begin
            bo_reg  <= sat16(48'(bo_reg) + 48'(lro_reg >>> 10));
            wo1_reg <= sat16(48'(wo1_reg) + 48'(m1 >>> 20));
            wo2_reg <= sat16(48'(wo2_reg) + 48'(m2 >>> 20));
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.omul) begin
            po1_reg <= 27'(wo1_reg) * 27'($signed({1'b0, h0}));
            po2_reg <= 27'(wo2_reg) * 27'($signed({1'b0, h1}));
        end
        if (ctrl.osum) begin
            net_reg <= sat16(48'(osum >>> 10));
        end
        if (ctrl.oact) begin
            s_reg <= activate(net_reg);
        end
        if (ctrl.d1) begin
            e_reg <= 23'(err) * 23'($signed({1'b0, s_reg}));
        end
        if (ctrl.d2) begin
            dout_reg <= dprod[30:20];
        end
        if (ctrl.d3) begin
            lro_reg <= 24'($signed({1'b0, lr})) * 24'(dout_reg);
        end
    end

    assign s    = s_reg;
    assign dout = dout_reg;
    assign wo1  = wo1_reg;
    assign wo2  = wo2_reg;

endmodule

[rtl/core/mlp_two_two_one_train_infer.sv]
// top level of the 2-2-1 perceptron: sequencer, hidden lanes, output merge
// depends on mlp221_pkg, mlp221_hlane, mlp221_merge
//
//  channel   dir  handshake                  payload
//  s_        in   s_tvalid / s_tready        s_tuser operation, s_tdata fields
//  m_        out  m_tvalid / m_tready        m_tdata three activations
//  cfg_      in   cfg_wr_en                  cfg_wr_data learning rate
//
// write items go straight to the final step; infer and train items walk
// the multiply, sum and table steps in order, train items then the delta steps
// reset clears all nine weights and sets the learning rate to 1.0
// a stalled result waits in the output register; the next item is
// accepted meanwhile and holds in its last step until the register frees
module mlp_two_two_one_train_infer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // first_input, second_input, target, weight_index, weight_value
    input  logic [63:0] s_tdata,
    // operation
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // network_output, first_hidden, second_hidden
    output logic [31:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data
);
    import mlp221_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_HMUL, ST_HSUM, ST_HACT, ST_OMUL, ST_OSUM, ST_OACT,
        ST_D1, ST_D2, ST_D3, ST_D4, ST_D5, ST_D6, ST_DONE
    } state_t;

    state_t             state_reg;
    logic [1:0]         op_reg;
    logic signed [15:0] x0_reg, x1_reg;
    logic [10:0]        tgt_reg;
    logic [11:0]        lr_reg;
    logic               m_tvalid_reg;
    logic [31:0]        m_tdata_reg;

    ctrl_t              ctrl;
    wr_t                lane_wr [HIDDEN_NEURONS];
    wr_t                out_wr;
    act_t               h [HIDDEN_NEURONS];
    logic signed [15:0] wo [HIDDEN_NEURONS];
    act_t               s;
    logic signed [10:0] dout;

    logic               accept;
    logic               do_wr;
    logic [3:0]         widx;
    logic [10:0]        tgt_in;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign widx     = s_tdata[46:43];
    assign do_wr    = accept && (s_tuser == OP_WRITE);
    assign tgt_in   = (s_tdata[42:32] > 11'd1024) ? 11'd1024 : s_tdata[42:32];

    always_comb begin
        for (int g = 0; g < HIDDEN_NEURONS; g++) begin
            lane_wr[g].en    = do_wr && (widx < 4'(HID_WEIGHTS)) && (widx[0] == 1'(g));
            lane_wr[g].row   = widx[2:1];
            lane_wr[g].value = $signed(s_tdata[62:47]);
        end
        out_wr.en    = do_wr && (widx >= 4'(HID_WEIGHTS))
                       && (widx < 4'(HID_WEIGHTS + OUT_WEIGHTS));
        out_wr.row   = 2'(widx - 4'(HID_WEIGHTS));
        out_wr.value = $signed(s_tdata[62:47]);
    end

    always_comb begin
        ctrl = '0;
        case (state_reg)
            ST_HMUL: ctrl.hmul = 1'b1;
            ST_HSUM: ctrl.hsum = 1'b1;
            ST_HACT: ctrl.hact = 1'b1;
            ST_OMUL: ctrl.omul = 1'b1;
            ST_OSUM: ctrl.osum = 1'b1;
            ST_OACT: ctrl.oact = 1'b1;
            ST_D1:   ctrl.d1   = 1'b1;
            ST_D2:   ctrl.d2   = 1'b1;
            ST_D3:   ctrl.d3   = 1'b1;
            ST_D4:   ctrl.d4   = 1'b1;
            ST_D5:   ctrl.d5   = 1'b1;
            ST_D6:   ctrl.d6   = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg <= LR_RESET;
        end else if (cfg_wr_en) begin
            lr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if ((state_reg == ST_DONE) && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        op_reg  <= s_tuser;
                        x0_reg  <= $signed(s_tdata[15:0]);
                        x1_reg  <= $signed(s_tdata[31:16]);
                        tgt_reg <= tgt_in;
                        state_reg <= (s_tuser == OP_WRITE) ? ST_DONE : ST_HMUL;
                    end
                end
                ST_HMUL: state_reg <= ST_HSUM;
                ST_HSUM: state_reg <= ST_HACT;
                ST_HACT: state_reg <= ST_OMUL;
                ST_OMUL: state_reg <= ST_OSUM;
                ST_OSUM: state_reg <= ST_OACT;
                ST_OACT: state_reg <= (op_reg == OP_TRAIN) ? ST_D1 : ST_DONE;
                ST_D1:   state_reg <= ST_D2;
                ST_D2:   state_reg <= ST_D3;
                ST_D3:   state_reg <= ST_D4;
                ST_D4:   state_reg <= ST_D5;
                ST_D5:   state_reg <= ST_D6;
                ST_D6:   state_reg <= ST_DONE;
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= (op_reg == OP_WRITE) ? '0
                                        : {2'b0, h[1], h[0], s};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    for (genvar g = 0; g < HIDDEN_NEURONS; g++) begin : g_lane
        mlp221_hlane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .wr      (lane_wr[g]),
            .x0      (x0_reg),
            .x1      (x1_reg),
            .dout    (dout),
            .wout    (wo[g]),
            .lr      (lr_reg),
            .h       (h[g])
        );
    end

    mlp221_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .wr      (out_wr),
        .h0      (h[0]),
        .h1      (h[1]),
        .tgt     (tgt_reg),
        .lr      (lr_reg),
        .s       (s),
        .dout    (dout),
        .wo1     (wo[0]),
        .wo2     (wo[1])
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the final step");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start the sequencer");

    a_write_skips_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_WRITE) |=> (state_reg == ST_DONE))
        else $error("weight write ran a forward pass");
`endif

endmodule

[dv/tb_mlp_two_two_one_train_infer.sv]
// testbench for the 2-2-1 perceptron: directed and random infer, train and weight write items
// checks every result against a built-in predictor of the weights and activations
// depends on mlp221_pkg and mlp_two_two_one_train_infer
class mlp_scoreboard;
    logic signed [15:0] hid_w [6];
    logic signed [15:0] out_w [3];
    logic [11:0] rate;
    logic [29:0] pending [$];
    int errors;
    int checked;

    function void clear_weights();
        foreach (hid_w[i]) hid_w[i] = '0;
        foreach (out_w[i]) out_w[i] = '0;
        rate = mlp221_pkg::LR_RESET;
    endfunction

    function longint floor_div(longint v, int sh);
        longint unit;
        unit = longint'(1) << sh;
        if (v >= 0) return v / unit;
        return -((-v + unit - 1) / unit);
    endfunction

    function longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function int step_sigmoid(longint net);
        int k;
        k = 0;
        while (k < mlp221_pkg::STEPS && net >= mlp221_pkg::EDGES[k]) k++;
        return mlp221_pkg::LEVELS[k];
    endfunction

    function void note_item(logic [1:0] op, logic [63:0] d);
        longint x [2];
        longint hv [2];
        longint dh [2];
        longint acc, s, tgt, dout, lr;
        int idx;
        if (op == mlp221_pkg::OP_WRITE) begin
            idx = d[46:43];
            if (idx < 6) hid_w[idx] = d[62:47];
            else if (idx < 9) out_w[idx-6] = d[62:47];
            pending.push_back('0);
            return;
        end
        x[0] = longint'($signed(d[15:0]));
        x[1] = longint'($signed(d[31:16]));
        for (int i = 0; i < 2; i++) begin
            acc = longint'(hid_w[i]) * 1024;
            for (int j = 0; j < 2; j++) acc += longint'(hid_w[(j+1)*2+i]) * x[j];
            hv[i] = step_sigmoid(clip16(floor_div(acc, 10)));
        end
        acc = longint'(out_w[0]) * 1024 + longint'(out_w[1]) * hv[0]
            + longint'(out_w[2]) * hv[1];
        s = step_sigmoid(clip16(floor_div(acc, 10)));
        pending.push_back({hv[1][9:0], hv[0][9:0], s[9:0]});
        if (op == mlp221_pkg::OP_TRAIN) begin
            lr = rate;
            tgt = d[42:32];
            if (tgt > 1024) tgt = 1024;
            dout = floor_div((tgt - s) * s * (1024 - s), 20);
            for (int i = 0; i < 2; i++)
                dh[i] = floor_div(dout * out_w[i+1] * hv[i] * (1024 - hv[i]), 30);
            out_w[0] = clip16(out_w[0] + floor_div(lr * dout * 1024, 20));
            for (int i = 0; i < 2; i++)
                out_w[i+1] = clip16(out_w[i+1] + floor_div(lr * dout * hv[i], 20));
            for (int i = 0; i < 2; i++) begin
                hid_w[i] = clip16(hid_w[i] + floor_div(lr * dh[i] * 1024, 20));
                for (int j = 0; j < 2; j++)
                    hid_w[(j+1)*2+i] = clip16(hid_w[(j+1)*2+i]
                        + floor_div(lr * dh[i] * x[j], 20));
            end
        end
    endfunction

    function void report(string what, int want, int got);
        errors++;
        if (errors <= 30) $display("mismatch %s: expected %0d got %0d", what, want, got);
    endfunction

    function void check_result(logic [31:0] r);
        logic [29:0] want;
        checked++;
        if (pending.size() == 0) begin
            report("result with nothing pending", 0, r[29:0]);
            return;
        end
        want = pending.pop_front();
        if (r[9:0] !== want[9:0]) report("network_output", want[9:0], r[9:0]);
        if (r[19:10] !== want[19:10]) report("first_hidden", want[19:10], r[19:10]);
        if (r[29:20] !== want[29:20]) report("second_hidden", want[29:20], r[29:20]);
    endfunction
endclass

module tb_mlp_two_two_one_train_infer;
    timeunit 1ns;
    timeprecision 1ps;
    import mlp221_pkg::*;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [31:0] m_tdata;
    logic cfg_wr_en = 0;
    logic [11:0] cfg_wr_data = '0;

    mlp_scoreboard sb;
    int send_idle = 0;
    int recv_idle = 0;
    int quiet = 0;
    int items_sent = 0;
    int n_train = 0;
    int n_write = 0;

    always #5 aclk = ~aclk;

    mlp_two_two_one_train_infer dut (.*);

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
            else quiet <= quiet + 1;
            if (quiet > 2000) begin
                $display("timeout, nothing moving");
                $display("mlp_two_two_one_train_infer test failed");
                $finish;
            end
        end
    end

    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_idle);

    task automatic send_item(logic [1:0] op, logic signed [15:0] a, logic signed [15:0] b,
                             logic [10:0] tgt, logic [3:0] idx, logic signed [15:0] w);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {1'b0, w, idx, tgt, b, a};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(op, {1'b0, w, idx, tgt, b, a});
        items_sent++;
        if (op == OP_TRAIN) n_train++;
        if (op == OP_WRITE) n_write++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic set_rate(logic [11:0] v);
        drain();
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 0;
        sb.rate = v;
    endtask

    function automatic logic signed [15:0] rand_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(4096) - 2048;
            2: return $urandom_range(1) ? 16'sh7fff : -16'sh8000;
            default: return $urandom_range(512) - 256;
        endcase
    endfunction

    task automatic random_item();
        int p;
        logic [1:0] op;
        p = $urandom_range(99);
        if (p < 45) op = OP_TRAIN;
        else if (p < 75) op = OP_INFER;
        else if (p < 95) op = OP_WRITE;
        else op = 2'd3;
        send_item(op, rand_value(), rand_value(),
                  ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(1024)),
                  ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(8)),
                  rand_value());
    endtask

    initial begin
        logic [11:0] rates [5];
        rates = '{12'd0, 12'd2048, 12'd4095, 12'd300, 12'd1024};
        sb = new();
        sb.clear_weights();
        repeat (2) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        send_item(OP_INFER, 0, 0, 0, 0, 0);
        for (int i = 0; i < 9; i++)
            send_item(OP_WRITE, 0, 0, 0, 4'(i), (i % 2) ? 16'sh7fff : -16'sh8000);
        send_item(OP_WRITE, 0, 0, 0, 4'd15, 16'sh1234);
        send_item(OP_INFER, 16'sh7fff, -16'sh8000, 0, 0, 0);
        send_item(OP_INFER, -16'sh8000, 16'sh7fff, 0, 0, 0);
        send_item(OP_TRAIN, 16'sh0400, 16'sh0400, 11'd1024, 0, 0);
        send_item(OP_TRAIN, 16'sh7fff, 16'sh7fff, 11'd2047, 0, 0);
        send_item(OP_TRAIN, -16'sh8000, 16'sh0100, 11'd0, 0, 0);
        send_item(2'd3, 16'sh0200, -16'sh0200, 11'd500, 4'd3, 16'sh0100);
        for (int i = 0; i < 9; i++) send_item(OP_WRITE, 0, 0, 0, 4'(i), 16'sh0200);
        send_item(OP_TRAIN, 16'sh0400, -16'sh0400, 11'd900, 0, 0);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 16 : (ph == 1) ? 74 : 0;
            recv_idle = (ph == 0) ? 74 : (ph == 1) ? 16 : 0;
            for (int r = 0; r < 5; r++) begin
                set_rate(rates[(r + ph) % 5]);
                for (int i = 0; i < 100; i++) begin
                    if (i == 50) drain();
                    random_item();
                end
            end
        end
        drain();
        $display("sent %0d items (%0d train, %0d write), checked %0d results",
                 items_sent, n_train, n_write, sb.checked);
        $display("learning rate covered 0, 300, 1.0, 2.0 and 4095 across three idle mixes");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("mlp_two_two_one_train_infer test passed");
        end else begin
            $display("mlp_two_two_one_train_infer test failed");
        end
        $finish;
    end
endmodule
